// ===== rtl/core/ffp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffp_pkg
// Types, character codes and helpers for the filename to FCB parser.
// ----------------------------------------------------------------------------
package ffp_pkg;

    // field lengths kept in the result
    localparam int NAME_LEN   = 8;
    localparam int TYPE_LEN   = 3;
    localparam int PASS_LEN   = 8;
    localparam int NAME_BYTES = 8;
    localparam int TYPE_BYTES = 3;
    localparam int PASS_BYTES = 8;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_P    = 8'h50;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRK    = 8'h5B;
    localparam logic [7:0] CH_RBRK    = 8'h5D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CASE_DIFF  = 8'h20;
    localparam logic [7:0] DRIVE_BASE = 8'h40;

    localparam logic [63:0] SPACES64 = {NAME_BYTES{CH_SPACE}};
    localparam logic [23:0] SPACES24 = {TYPE_BYTES{CH_SPACE}};

    typedef enum logic [3:0] {
        PH_DONE  = 4'd0,
        PH_SKIP  = 4'd1,
        PH_HOLD  = 4'd2,
        PH_NAME  = 4'd3,
        PH_NSKIP = 4'd4,
        PH_TYPE  = 4'd5,
        PH_TSKIP = 4'd6,
        PH_PCHK  = 4'd7,
        PH_PASS  = 4'd8,
        PH_PSKIP = 4'd9
    } ffp_phase_t;

    typedef enum logic [1:0] {
        ST_END     = 2'd0,
        ST_DELIM   = 2'd1,
        ST_INVALID = 2'd2
    } ffp_status_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } ffp_in_t;

    typedef struct packed {
        logic [4:0]  drive;
        logic [63:0] name_chars;
        logic [23:0] type_chars;
        logic [63:0] pass_chars;
        logic [3:0]  pass_len;
        logic [1:0]  status;
        logic [15:0] stop_offset;
    } ffp_out_t;

    // parse state carried through one character step
    typedef struct packed {
        ffp_phase_t  phase;
        logic [3:0]  fidx;
        logic [63:0] name_chars;
        logic [23:0] type_chars;
        logic [63:0] pass_chars;
    } ffp_fields_t;

    typedef struct packed {
        logic        done;
        ffp_status_t status;
        logic [3:0]  pass_len;
    } ffp_fin_t;

    function automatic logic is_term(input logic [7:0] c);
        logic r;
        case (c) inside
            CH_SPACE, CH_TAB, CH_CR, CH_NUL, CH_SEMI, CH_EQ, CH_GT, CH_LT,
            CH_COMMA, CH_LBRK, CH_RBRK, CH_SLASH, CH_BAR: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_fchar(input logic [7:0] c);
        logic r;
        case (c) inside
            CH_QUEST, CH_STAR, [CH_DIGIT0:CH_DIGIT9], [CH_UP_A:CH_UP_Z],
            [CH_LO_A:CH_LO_Z], CH_DASH, CH_UNDER, CH_BANG: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // character that closes a name, type or password field
    function automatic logic is_field_end(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_COLON) || is_term(c);
    endfunction

    function automatic logic [7:0] upc(input logic [7:0] c);
        logic [7:0] r;
        case (c) inside
            [CH_LO_A:CH_LO_Z]: r = c - CASE_DIFF;
            default:           r = c;
        endcase
        return r;
    endfunction

    function automatic ffp_status_t end_status(input logic [7:0] c);
        return ((c == CH_NUL) || (c == CH_CR)) ? ST_END : ST_DELIM;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    endfunction

endpackage

// ===== rtl/core/filename_to_fcb_parser.sv =====
// ----------------------------------------------------------------------------
// filename_to_fcb_parser
// Streams a filename one byte at a time and returns drive, name, type and
// password fields once the parse ends.
// ----------------------------------------------------------------------------
//   channel   | ports                      | carries
//   ----------+----------------------------+-------------------------------
//   input     | s_valid s_ready s_data     | ch, first flag
//   result    | m_valid m_ready m_data     | drive, name, type, password,
//             |                            | length, status, stop offset
//
// One byte is taken every cycle while s_ready is high; the parse state updates in the same cycle.
// A result appears on m_valid the cycle after the byte that ends the parse.
// s_ready drops only while a result sits unclaimed with m_ready low.
// After reset the parser ignores bytes until one arrives with first set.
// ----------------------------------------------------------------------------
module filename_to_fcb_parser import ffp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ffp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ffp_out_t m_data
);

    ffp_phase_t  phase_reg;
    logic [3:0]  fidx_reg;
    logic [7:0]  held_reg,  held_next;
    logic [4:0]  drive_reg, drive_next;
    logic [63:0] name_reg;
    logic [23:0] type_reg;
    logic [63:0] pass_reg;
    logic [15:0] count_reg, count_next;
    logic        m_valid_reg;
    ffp_out_t    m_data_reg;

    ffp_fields_t base_fld, fld_next, a_in, a_out, b_out;
    ffp_fin_t    a_fin, b_fin, fin_sel;
    logic [7:0]  base_held, a_ch, drv_up;
    logic [4:0]  base_drive;
    logic [15:0] base_count, count_inc, count_inc2, off_sel;
    ffp_out_t    res;
    logic        accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a first flag restarts the parse from cleared fields
    always_comb begin
        if (s_data.first) begin
            base_fld   = '{phase: PH_SKIP, fidx: 4'd0, name_chars: SPACES64,
                           type_chars: SPACES24, pass_chars: 64'd0};
            base_held  = CH_NUL;
            base_drive = 5'd0;
            base_count = 16'd0;
        end else begin
            base_fld   = '{phase: phase_reg, fidx: fidx_reg, name_chars: name_reg,
                           type_chars: type_reg, pass_chars: pass_reg};
            base_held  = held_reg;
            base_drive = drive_reg;
            base_count = count_reg;
        end
    end

    assign count_inc  = sat_inc(base_count);
    assign count_inc2 = sat_inc(count_inc);
    assign drv_up     = upc(base_held);

    always_comb begin
        a_in = base_fld;
        if (base_fld.phase == PH_SKIP || base_fld.phase == PH_HOLD) begin
            a_in.phase = PH_NAME;
            a_in.fidx  = 4'd0;
        end
    end

    assign a_ch = (base_fld.phase == PH_HOLD) ? base_held : s_data.ch;

    // held character first, then the current byte if the held one did not end it
    ffp_char_step u_step_a (
        .st_in  (a_in),
        .ch     (a_ch),
        .st_out (a_out),
        .fin    (a_fin)
    );

    ffp_char_step u_step_b (
        .st_in  (a_out),
        .ch     (s_data.ch),
        .st_out (b_out),
        .fin    (b_fin)
    );

    always_comb begin
        fld_next   = base_fld;
        held_next  = base_held;
        drive_next = base_drive;
        count_next = base_count;
        fin_sel    = '{done: 1'b0, status: ST_END, pass_len: 4'd0};
        off_sel    = base_count;
        case (base_fld.phase)
            PH_DONE: begin
            end
            PH_SKIP: begin
                if (s_data.ch == CH_SPACE || s_data.ch == CH_TAB) begin
                    count_next = count_inc;
                end else if (s_data.ch == CH_NUL) begin
                    count_next = count_inc;
                    fld_next   = a_out;
                    fin_sel    = a_fin;
                end else begin
                    held_next      = s_data.ch;
                    fld_next.phase = PH_HOLD;
                end
            end
            PH_HOLD: begin
                count_next = count_inc2;
                if (s_data.ch == CH_COLON) begin
                    fld_next = a_in;
                    if (drv_up >= CH_UP_A && drv_up <= CH_UP_P) begin
                        drive_next = 5'(drv_up - DRIVE_BASE);
                    end else begin
                        fld_next.phase = PH_DONE;
                        fin_sel = '{done: 1'b1, status: ST_INVALID, pass_len: 4'd0};
                        off_sel = count_inc;
                    end
                end else if (a_fin.done) begin
                    fld_next = a_out;
                    fin_sel  = a_fin;
                end else begin
                    fld_next = b_out;
                    fin_sel  = b_fin;
                    off_sel  = count_inc;
                end
            end
            default: begin
                count_next = count_inc;
                fld_next   = a_out;
                fin_sel    = a_fin;
            end
        endcase
    end

    // fields are unchanged by a finishing step, so the next state carries them
    always_comb begin
        res.status      = fin_sel.status;
        res.stop_offset = off_sel;
        if (fin_sel.status == ST_INVALID) begin
            res.drive      = 5'd0;
            res.name_chars = 64'd0;
            res.type_chars = 24'd0;
            res.pass_chars = 64'd0;
            res.pass_len   = 4'd0;
        end else begin
            res.drive      = base_drive;
            res.name_chars = fld_next.name_chars;
            res.type_chars = fld_next.type_chars;
            res.pass_chars = fld_next.pass_chars;
            res.pass_len   = fin_sel.pass_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
        end else if (accept) begin
            phase_reg <= fld_next.phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fidx_reg  <= fld_next.fidx;
            name_reg  <= fld_next.name_chars;
            type_reg  <= fld_next.type_chars;
            pass_reg  <= fld_next.pass_chars;
            held_reg  <= held_next;
            drive_reg <= drive_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && fin_sel.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && fin_sel.done) begin
            m_data_reg <= res;
        end
    end

    a_stall_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result stalled");

    a_reset_clears_result : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_done_after_result : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fin_sel.done |=> phase_reg == PH_DONE && m_valid)
        else $error("parse not closed after result");

    a_invalid_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_INVALID |->
            m_data.drive == 5'd0 && m_data.pass_len == 4'd0)
        else $error("invalid result carries fields");

    a_pass_len_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pass_len <= 4'(PASS_LEN) && m_data.status != 2'd3)
        else $error("result length or status out of range");

endmodule

// ===== rtl/core/ffp_char_step.sv =====
// ----------------------------------------------------------------------------
// ffp_char_step
// Applies one character to the name/type/password parse state.
// ----------------------------------------------------------------------------
module ffp_char_step import ffp_pkg::*; (
    input  ffp_fields_t st_in,
    input  logic [7:0]  ch,
    output ffp_fields_t st_out,
    output ffp_fin_t    fin
);

    ffp_fields_t st;
    ffp_fin_t    fin_v;
    logic        stop;
    logic [7:0]  ch_up;

    assign ch_up = upc(ch);

    // Phases only fall through forward, so one ordered pass covers every chain.
    always_comb begin
        st    = st_in;
        fin_v = '{done: 1'b0, status: ST_END, pass_len: 4'd0};
        stop  = 1'b0;

        if (st.phase == PH_NAME) begin
            if (st.fidx >= 4'(NAME_LEN)) begin
                st.phase = PH_NSKIP;
            end else if (ch == CH_STAR) begin
                for (int k = 0; k < NAME_BYTES; k++) begin
                    if (k < NAME_LEN && 4'(k) >= st.fidx) begin
                        st.name_chars[(NAME_BYTES-1-k)*8 +: 8] = CH_QUEST;
                    end
                end
                st.phase = PH_NSKIP;
                stop     = 1'b1;
            end else if (is_field_end(ch)) begin
                st.phase = PH_NSKIP;
            end else if (!is_fchar(ch)) begin
                fin_v    = '{done: 1'b1, status: ST_INVALID, pass_len: 4'd0};
                st.phase = PH_DONE;
                stop     = 1'b1;
            end else begin
                for (int k = 0; k < NAME_BYTES; k++) begin
                    if (st.fidx == 4'(k)) begin
                        st.name_chars[(NAME_BYTES-1-k)*8 +: 8] = ch_up;
                    end
                end
                st.fidx = st.fidx + 4'd1;
                if (st.fidx >= 4'(NAME_LEN)) begin
                    st.phase = PH_NSKIP;
                end
                stop = 1'b1;
            end
        end

        if (!stop && st.phase == PH_NSKIP) begin
            if (!is_field_end(ch)) begin
                if (!is_fchar(ch)) begin
                    fin_v    = '{done: 1'b1, status: ST_INVALID, pass_len: 4'd0};
                    st.phase = PH_DONE;
                end
                stop = 1'b1;
            end else if (ch == CH_DOT) begin
                st.phase = PH_TYPE;
                st.fidx  = 4'd0;
                stop     = 1'b1;
            end else begin
                st.phase = PH_PCHK;
            end
        end

        if (!stop && st.phase == PH_TYPE) begin
            if (st.fidx >= 4'(TYPE_LEN)) begin
                st.phase = PH_TSKIP;
            end else if (ch == CH_STAR) begin
                for (int k = 0; k < TYPE_BYTES; k++) begin
                    if (k < TYPE_LEN && 4'(k) >= st.fidx) begin
                        st.type_chars[(TYPE_BYTES-1-k)*8 +: 8] = CH_QUEST;
                    end
                end
                st.phase = PH_TSKIP;
                stop     = 1'b1;
            end else if (is_field_end(ch)) begin
                st.phase = PH_TSKIP;
            end else if (!is_fchar(ch)) begin
                fin_v    = '{done: 1'b1, status: ST_INVALID, pass_len: 4'd0};
                st.phase = PH_DONE;
                stop     = 1'b1;
            end else begin
                for (int k = 0; k < TYPE_BYTES; k++) begin
                    if (st.fidx == 4'(k)) begin
                        st.type_chars[(TYPE_BYTES-1-k)*8 +: 8] = ch_up;
                    end
                end
                st.fidx = st.fidx + 4'd1;
                if (st.fidx >= 4'(TYPE_LEN)) begin
                    st.phase = PH_TSKIP;
                end
                stop = 1'b1;
            end
        end

        if (!stop && st.phase == PH_TSKIP) begin
            if (!is_field_end(ch)) begin
                if (!is_fchar(ch)) begin
                    fin_v    = '{done: 1'b1, status: ST_INVALID, pass_len: 4'd0};
                    st.phase = PH_DONE;
                end
                stop = 1'b1;
            end else begin
                st.phase = PH_PCHK;
            end
        end

        if (!stop && st.phase == PH_PCHK) begin
            if (ch == CH_SEMI) begin
                st.phase = PH_PASS;
                st.fidx  = 4'd0;
            end else begin
                fin_v    = '{done: 1'b1, status: end_status(ch), pass_len: 4'd0};
                st.phase = PH_DONE;
            end
            stop = 1'b1;
        end

        if (!stop && st.phase == PH_PASS) begin
            if (st.fidx >= 4'(PASS_LEN)) begin
                st.phase = PH_PSKIP;
            end else if (!is_field_end(ch)) begin
                for (int k = 0; k < PASS_BYTES; k++) begin
                    if (st.fidx == 4'(k)) begin
                        st.pass_chars[(PASS_BYTES-1-k)*8 +: 8] = ch_up;
                    end
                end
                st.fidx = st.fidx + 4'd1;
                stop    = 1'b1;
            end else begin
                fin_v    = '{done: 1'b1, status: end_status(ch), pass_len: st.fidx};
                st.phase = PH_DONE;
                stop     = 1'b1;
            end
        end

        if (!stop && st.phase == PH_PSKIP) begin
            if (is_field_end(ch)) begin
                fin_v    = '{done: 1'b1, status: end_status(ch), pass_len: st.fidx};
                st.phase = PH_DONE;
            end
        end

        st_out = st;
        fin    = fin_v;
    end

endmodule

// ===== verif/filename_to_fcb_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filename_to_fcb_parser_tb
// Streams filename strings into the parser and checks every result against a
// cycle-free prediction: drive prefix, name and type fields with wildcards,
// password cut, stop status and saturating byte offset, under random stalls.
// ----------------------------------------------------------------------------
module filename_to_fcb_parser_tb;
    import ffp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NO_TAIL        = -1;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ffp_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ffp_out_t m_data;

    filename_to_fcb_parser u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // parser state as predicted
    ffp_phase_t  pr_phase = PH_DONE;
    logic [7:0]  pr_held  = '0;
    logic [4:0]  pr_drive = '0;
    logic [63:0] pr_name  = SPACES64;
    logic [23:0] pr_type  = SPACES24;
    logic [63:0] pr_pass  = '0;
    logic [3:0]  pr_idx   = '0;
    logic [15:0] pr_count = '0;

    ffp_out_t   expected_fcb_q[$];
    logic [7:0] pending_str[$];

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_start  = 0;
    int rx_hold_seen   = 0;
    int rx_hold_left   = 0;
    int fail_count     = 0;
    int results_seen   = 0;
    int parsed_chars   = 0;
    int strings_sent   = 0;
    int stall_cycles   = 0;

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic bit is_stop(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NUL ||
               c == CH_SEMI || c == CH_EQ || c == CH_GT || c == CH_LT ||
               c == CH_COMMA || c == CH_LBRK || c == CH_RBRK || c == CH_SLASH ||
               c == CH_BAR;
    endfunction

    function automatic bit is_field_stop(input logic [7:0] c);
        return c == CH_DOT || c == CH_COLON || is_stop(c);
    endfunction

    function automatic bit is_name_char(input logic [7:0] c);
        return c == CH_QUEST || c == CH_STAR || c == CH_DASH || c == CH_UNDER ||
               c == CH_BANG || (c >= CH_DIGIT0 && c <= CH_DIGIT9) ||
               (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_DIFF : c;
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == CNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic ffp_status_t stop_kind(input logic [7:0] c);
        return (c == CH_NUL || c == CH_CR) ? ST_END : ST_DELIM;
    endfunction

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic void close_parse(input ffp_status_t st, input logic [15:0] off);
        ffp_out_t fcb;
        fcb = '0;
        if (st != ST_INVALID) begin
            fcb.drive      = pr_drive;
            fcb.name_chars = pr_name;
            fcb.type_chars = pr_type;
            fcb.pass_chars = pr_pass;
            fcb.pass_len   = (pr_phase == PH_PASS || pr_phase == PH_PSKIP) ? pr_idx : 4'd0;
        end
        fcb.status      = st;
        fcb.stop_offset = off;
        expected_fcb_q.push_back(fcb);
        pr_phase = PH_DONE;
    endfunction

    // advance the field phases on one character; return 1 when the parse ends
    function automatic bit parse_byte(input logic [7:0] c, input logic [15:0] off);
        bit again;
        bit ended;
        again = 1'b1;
        ended = 1'b0;
        while (again) begin
            again = 1'b0;
            case (pr_phase)
                PH_NAME: begin
                    if (pr_idx >= NAME_LEN) begin
                        pr_phase = PH_NSKIP;
                        again    = 1'b1;
                    end else if (c == CH_STAR) begin
                        for (int i = pr_idx; i < NAME_LEN; i++)
                            pr_name[(NAME_BYTES - 1 - i) * 8 +: 8] = CH_QUEST;
                        pr_phase = PH_NSKIP;
                    end else if (is_field_stop(c)) begin
                        pr_phase = PH_NSKIP;
                        again    = 1'b1;
                    end else if (!is_name_char(c)) begin
                        close_parse(ST_INVALID, off);
                        ended = 1'b1;
                    end else begin
                        pr_name[(NAME_BYTES - 1 - pr_idx) * 8 +: 8] = to_upper(c);
                        pr_idx = pr_idx + 4'd1;
                        if (pr_idx >= NAME_LEN) pr_phase = PH_NSKIP;
                    end
                end
                PH_NSKIP: begin
                    if (!is_field_stop(c)) begin
                        if (!is_name_char(c)) begin
                            close_parse(ST_INVALID, off);
                            ended = 1'b1;
                        end
                    end else if (c == CH_DOT) begin
                        pr_phase = PH_TYPE;
                        pr_idx   = '0;
                    end else begin
                        pr_phase = PH_PCHK;
                        again    = 1'b1;
                    end
                end
                PH_TYPE: begin
                    if (pr_idx >= TYPE_LEN) begin
                        pr_phase = PH_TSKIP;
                        again    = 1'b1;
                    end else if (c == CH_STAR) begin
                        for (int i = pr_idx; i < TYPE_LEN; i++)
                            if (i < TYPE_BYTES) pr_type[(TYPE_BYTES - 1 - i) * 8 +: 8] = CH_QUEST;
                        pr_phase = PH_TSKIP;
                    end else if (is_field_stop(c)) begin
                        pr_phase = PH_TSKIP;
                        again    = 1'b1;
                    end else if (!is_name_char(c)) begin
                        close_parse(ST_INVALID, off);
                        ended = 1'b1;
                    end else begin
                        if (pr_idx < TYPE_BYTES)
                            pr_type[(TYPE_BYTES - 1 - pr_idx) * 8 +: 8] = to_upper(c);
                        pr_idx = pr_idx + 4'd1;
                        if (pr_idx >= TYPE_LEN) pr_phase = PH_TSKIP;
                    end
                end
                PH_TSKIP: begin
                    if (!is_field_stop(c)) begin
                        if (!is_name_char(c)) begin
                            close_parse(ST_INVALID, off);
                            ended = 1'b1;
                        end
                    end else begin
                        pr_phase = PH_PCHK;
                        again    = 1'b1;
                    end
                end
                PH_PCHK: begin
                    if (c == CH_SEMI) begin
                        pr_phase = PH_PASS;
                        pr_idx   = '0;
                    end else begin
                        close_parse(stop_kind(c), off);
                        ended = 1'b1;
                    end
                end
                PH_PASS: begin
                    if (pr_idx >= PASS_LEN) begin
                        pr_phase = PH_PSKIP;
                        again    = 1'b1;
                    end else if (!is_field_stop(c)) begin
                        pr_pass[(PASS_BYTES - 1 - pr_idx) * 8 +: 8] = to_upper(c);
                        pr_idx = pr_idx + 4'd1;
                    end else begin
                        close_parse(stop_kind(c), off);
                        ended = 1'b1;
                    end
                end
                PH_PSKIP: begin
                    if (is_field_stop(c)) begin
                        close_parse(stop_kind(c), off);
                        ended = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return ended;
    endfunction

    // one accepted request; return 1 when the parser actually uses the byte
    function automatic bit predict_char(input logic [7:0] c, input logic first);
        logic [15:0] cur;
        logic [15:0] held_off;
        logic [7:0]  letter;
        if (first) begin
            pr_held  = '0;
            pr_drive = '0;
            pr_name  = SPACES64;
            pr_type  = SPACES24;
            pr_pass  = '0;
            pr_idx   = '0;
            pr_count = '0;
            pr_phase = PH_SKIP;
        end
        if (pr_phase == PH_DONE) return 1'b0;

        if (pr_phase == PH_SKIP) begin
            cur = pr_count;
            if (c == CH_SPACE || c == CH_TAB) begin
                pr_count = bump16(cur);
            end else if (c == CH_NUL) begin
                pr_phase = PH_NAME;
                pr_idx   = '0;
                pr_count = bump16(cur);
                void'(parse_byte(c, cur));
            end else begin
                // hold the first character until we know whether ':' follows
                pr_held  = c;
                pr_phase = PH_HOLD;
            end
        end else if (pr_phase == PH_HOLD) begin
            held_off = pr_count;
            cur      = bump16(held_off);
            pr_count = bump16(cur);
            pr_phase = PH_NAME;
            pr_idx   = '0;
            if (c == CH_COLON) begin
                letter = to_upper(pr_held);
                if (letter < CH_UP_A || letter > CH_UP_P) close_parse(ST_INVALID, cur);
                else pr_drive = 5'(letter - DRIVE_BASE);
            end else if (!parse_byte(pr_held, held_off)) begin
                void'(parse_byte(c, cur));
            end
        end else begin
            cur      = pr_count;
            pr_count = bump16(cur);
            void'(parse_byte(c, cur));
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // result side: ready pattern, long hold-off, checking
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_start) begin
            rx_hold_seen <= rx_hold_start;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        ffp_out_t want_fcb;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fcb_q.size() == 0) begin
                $error("result with no request pending: %0h", m_data);
                fail_count++;
            end else begin
                want_fcb = expected_fcb_q.pop_front();
                check_field("drive", want_fcb.drive, m_data.drive);
                check_field("name_chars", want_fcb.name_chars, m_data.name_chars);
                check_field("type_chars", want_fcb.type_chars, m_data.type_chars);
                check_field("pass_chars", want_fcb.pass_chars, m_data.pass_chars);
                check_field("pass_len", want_fcb.pass_len, m_data.pass_len);
                check_field("status", want_fcb.status, m_data.status);
                check_field("stop_offset", want_fcb.stop_offset, m_data.stop_offset);
                results_seen++;
            end
        end
    end

    // end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("filename_to_fcb_parser test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic first);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{ch: c, first: first};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_char(c, first)) parsed_chars++;
    endtask

    task automatic send_pending();
        foreach (pending_str[i]) send_char(pending_str[i], i == 0);
        strings_sent++;
    endtask

    task automatic send_text(input string txt, input int tail);
        pending_str.delete();
        for (int i = 0; i < txt.len(); i++) pending_str.push_back(txt[i]);
        if (tail != NO_TAIL) pending_str.push_back(tail[7:0]);
        send_pending();
    endtask

    task automatic wait_drained();
        while (expected_fcb_q.size() > 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_name_char();
        case ($urandom_range(5))
            0:       return 8'($urandom_range(CH_DIGIT9, CH_DIGIT0));
            1, 2:    return 8'($urandom_range(CH_LO_Z, CH_LO_A));
            3:       begin
                case ($urandom_range(3))
                    0:       return CH_DASH;
                    1:       return CH_UNDER;
                    2:       return CH_BANG;
                    default: return CH_QUEST;
                endcase
            end
            default: return 8'($urandom_range(CH_UP_Z, CH_UP_A));
        endcase
    endfunction

    function automatic logic [7:0] rand_delim();
        case ($urandom_range(12))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_SEMI;
            3:       return CH_EQ;
            4:       return CH_GT;
            5:       return CH_LT;
            6:       return CH_COMMA;
            7:       return CH_LBRK;
            8:       return CH_RBRK;
            9:       return CH_SLASH;
            10:      return CH_BAR;
            11:      return CH_COLON;
            default: return CH_DOT;
        endcase
    endfunction

    // name or type text with occasional wildcard or illegal character
    function automatic void push_field(input int max_len);
        logic [7:0] c;
        int pick;
        repeat ($urandom_range(max_len)) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                c = CH_STAR;
            end else if (pick < 9) begin
                do c = 8'($urandom_range(255));
                while (is_name_char(c) || is_field_stop(c));
            end else begin
                c = rand_name_char();
            end
            pending_str.push_back(c);
        end
    endfunction

    task automatic send_random_string();
        logic [7:0] c;
        int pick;
        int keep;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // noise: raw bytes with stray first flags
            repeat ($urandom_range(6, 1))
                send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
        end else begin
            pending_str.delete();
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1))
                    pending_str.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
            if ($urandom_range(9) < 3) begin
                if ($urandom_range(4) != 0)
                    c = 8'($urandom_range(CH_UP_P, CH_UP_A)) |
                        ($urandom_range(1) ? CASE_DIFF : 8'h00);
                else
                    c = 8'($urandom_range(255));
                pending_str.push_back(c);
                pending_str.push_back(CH_COLON);
            end
            push_field(NAME_LEN + 2);
            if ($urandom_range(1)) begin
                pending_str.push_back(CH_DOT);
                push_field(TYPE_LEN + 2);
            end
            if ($urandom_range(9) < 3) begin
                pending_str.push_back(CH_SEMI);
                repeat ($urandom_range(PASS_LEN + 3)) begin
                    do c = 8'($urandom_range(255));
                    while (is_field_stop(c));
                    pending_str.push_back(c);
                end
            end
            if ($urandom_range(9) == 0) begin
                // cut short; the next first flag abandons it
                keep = $urandom_range(pending_str.size(), 1);
                while (pending_str.size() > keep) void'(pending_str.pop_back());
            end else begin
                pick = $urandom_range(99);
                pending_str.push_back(pick < 40 ? CH_NUL : pick < 60 ? CH_CR : rand_delim());
            end
            if (pending_str.size() == 0) pending_str.push_back(CH_NUL);
            send_pending();
            repeat ($urandom_range(2)) send_char(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_bytes_before_first();
        send_char(CH_UP_A, 1'b0);
        send_char(CH_NUL, 1'b0);
    endtask

    task automatic test_directed_strings();
        send_text(" \tb:foo.c;pw", CH_NUL);
        send_text("Q:x", CH_NUL);                 // bad drive letter
        send_text("p:", CH_NUL);                  // highest drive, empty name
        send_text("*.*", CH_CR);
        send_text("", CH_NUL);                    // empty string
        send_text("a", CH_NUL);                   // held character then end
        send_text("#a", NO_TAIL);                 // held character is illegal
        send_text(";x", CH_CR);                   // held character opens password
        send_text("longname12.type;password99", CH_NUL);
        send_text("ab,cd", NO_TAIL);              // stop at delimiter, rest ignored
        send_text("a~b", CH_NUL);
        send_text("abc", NO_TAIL);                // abandoned by next first
        send_text("z", CH_NUL);
    endtask

    task automatic test_random_strings(input int tx_pct, input int rx_pct, input int count);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        target = parsed_chars + count;
        while (parsed_chars < target) send_random_string();
    endtask

    task automatic test_result_stall();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        rx_hold_start <= rx_hold_start + 1;
        repeat (40) send_text("a", CH_NUL);
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_bytes_before_first();
        test_directed_strings();
        test_random_strings(22, 78, 580);
        test_random_strings(78, 22, 580);
        test_random_strings(0, 0, 590);
        test_result_stall();

        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("parsed %0d bytes in %0d strings, checked %0d results, %0d errors",
                 parsed_chars, strings_sent, results_seen, fail_count);
        $display("covered drive prefixes, wildcards, cut fields, noise bytes, long stall");
        if (fail_count == 0) begin
            $display("filename_to_fcb_parser test passed");
        end else begin
            $display("filename_to_fcb_parser test failed");
        end
        $finish;
    end

endmodule
